### hdl/dnsf_pkg.sv
package dnsf_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
  localparam int BYTE_W       = 8;
  localparam int POS_W        = 6;

  localparam logic [BYTE_W-1:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } ctrl_state_t;

  // one output word
  typedef struct packed {
    logic [BYTE_W-1:0] sentence_byte;
    logic [POS_W-1:0]  byte_position;
    logic              sentence_last;
  } out_word_t;

  // read issued to the store, with the tags that travel alongside it
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    logic             last;
  } rd_req_t;

endpackage

### hdl/dnsf_if.sv
interface dnsf_rx_if;
  import dnsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dnsf_sent_if;
  import dnsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] sentence_byte;
  logic [POS_W-1:0]  byte_position;
  logic              sentence_last;

  modport source (output valid, output sentence_byte, output byte_position,
                  output sentence_last, input ready);
  modport sink   (input valid, input sentence_byte, input byte_position,
                  input sentence_last, output ready);
endinterface

### hdl/dnsf_ram.sv
module dnsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/dnsf_ctrl.sv
module dnsf_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  dnsf_rx_if.sink                 rx,
  input  logic                    room,
  output logic                    wr_en,
  output logic [dnsf_pkg::ADDR_W-1:0] wr_addr,
  output logic [dnsf_pkg::BYTE_W-1:0] wr_data,
  output logic [dnsf_pkg::ADDR_W-1:0] rd_addr,
  output dnsf_pkg::rd_req_t       rd_req
);
  import dnsf_pkg::*;

  ctrl_state_t       state, state_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic              in_sent, in_sent_next;
  logic [FILL_W-1:0] idx, idx_next;
  logic [FILL_W-1:0] len, len_next;

  logic accept;
  logic is_dollar;
  logic is_newline;
  logic full;
  logic issue;
  logic issue_last;

  assign accept     = rx.valid && rx.ready;
  assign is_dollar  = (rx.rx_byte == CHAR_DOLLAR);
  assign is_newline = (rx.rx_byte == CHAR_NEWLINE);
  assign full       = (fill >= FILL_W'(BUFFER_DEPTH));
  assign issue_last = ((idx + FILL_W'(1)) == len);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_FILL: begin
        if (accept && !is_dollar && in_sent && !full && is_newline) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (room && issue_last) begin
          state_next = ST_FILL;
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  // outputs
  always_comb begin
    rx.ready = 1'b0;
    issue    = 1'b0;
    case (state)
      ST_FILL: rx.ready = 1'b1;
      ST_EMIT: issue    = room;
      default: ;
    endcase
  end

  // store writes and sentence bookkeeping
  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = fill[ADDR_W-1:0];
    wr_data      = rx.rx_byte;
    fill_next    = fill;
    in_sent_next = in_sent;
    len_next     = len;
    idx_next     = idx;
    if (accept) begin
      if (is_dollar) begin
        wr_en        = 1'b1;
        wr_addr      = '0;
        fill_next    = FILL_W'(1);
        in_sent_next = 1'b1;
      end else if (in_sent) begin
        if (full) begin
          // overflow: drop the sentence and wait for a dollar
          fill_next    = '0;
          in_sent_next = 1'b0;
        end else begin
          wr_en     = 1'b1;
          fill_next = fill + FILL_W'(1);
          if (is_newline) begin
            len_next     = fill + FILL_W'(1);
            idx_next     = '0;
            fill_next    = '0;
            in_sent_next = 1'b0;
          end
        end
      end
    end
    if (issue) begin
      idx_next = idx + FILL_W'(1);
    end
  end

  assign rd_addr     = idx[ADDR_W-1:0];
  assign rd_req.valid = issue;
  assign rd_req.pos   = POS_W'(idx);
  assign rd_req.last  = issue_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_FILL;
      fill    <= '0;
      in_sent <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      in_sent <= in_sent_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    len <= len_next;
  end

endmodule

### hdl/dnsf_outq.sv
module dnsf_outq (
  input  logic                        clk,
  input  logic                        rst,
  input  dnsf_pkg::rd_req_t           rd_req,
  input  logic [dnsf_pkg::BYTE_W-1:0] rd_data,
  output logic                        room,
  dnsf_sent_if.source                 sent
);
  import dnsf_pkg::*;

  logic             pend;
  logic [POS_W-1:0] pend_pos;
  logic             pend_last;

  logic      out_valid, out_valid_next;
  out_word_t out_word, out_word_next;
  logic      skid_valid, skid_valid_next;
  out_word_t skid_word, skid_word_next;

  out_word_t arr_word;
  logic      pop;
  logic [1:0] occ;

  assign arr_word = '{sentence_byte: rd_data, byte_position: pend_pos,
                      sentence_last: pend_last};
  assign pop  = out_valid && sent.ready;
  // words held or in flight from the store; never more than two
  assign occ  = 2'(out_valid) + 2'(skid_valid) + 2'(pend);
  assign room = (occ < 2'd2) || pop;

  always_comb begin
    out_valid_next  = out_valid;
    out_word_next   = out_word;
    skid_valid_next = skid_valid;
    skid_word_next  = skid_word;
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid_next  = 1'b1;
        out_word_next   = skid_word;
        skid_valid_next = pend;
        skid_word_next  = arr_word;
      end else begin
        out_valid_next = pend;
        out_word_next  = arr_word;
      end
    end else if (pend) begin
      skid_valid_next = 1'b1;
      skid_word_next  = arr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      pend       <= rd_req.valid;
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_pos  <= rd_req.pos;
    pend_last <= rd_req.last;
    out_word  <= out_word_next;
    skid_word <= skid_word_next;
  end

  assign sent.valid         = out_valid;
  assign sent.sentence_byte = out_word.sentence_byte;
  assign sent.byte_position = out_word.byte_position;
  assign sent.sentence_last = out_word.sentence_last;

endmodule

### hdl/dollar_newline_sentence_framer_core.sv
// Sentence framer: frames text sentences that open with '$' and close with a
// newline, then replays each finished sentence one word per character.
// rx:   one received character per word (rx_byte).
// sent: sentence_byte, byte_position (0 is the '$') and sentence_last, set
//       on the closing newline only.
// A '$' always restarts the sentence; characters outside a sentence are
// dropped. A sentence longer than the 64-entry store is discarded silently
// and the framer waits for the next '$'.
// Throughput: one rx word per cycle while a sentence is filling. The
// closing newline starts a replay of N words (N = sentence length); rx is
// held off while the store's single read port walks the sentence, one
// read per cycle while the output stage has room. Each read word is
// registered at the store's read port before it enters the output stage.
// Stalls on sent are absorbed by an output register plus one skid word;
// the read sequencer pauses while two words are held or in flight and
// none is taken, and resumes without loss. Once every read of a sentence
// is issued, rx is taken again even if words still wait on sent.
// Reset clears the framer state and empties the output stage; the store
// itself is not cleared, only entries already written are ever read.
module dollar_newline_sentence_framer_core (
  input  logic        clk,
  input  logic        rst,
  dnsf_rx_if.sink     rx,
  dnsf_sent_if.source sent
);
  import dnsf_pkg::*;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  rd_req_t           rd_req;
  logic              room;

  dnsf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .room    (room),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_req  (rd_req)
  );

  dnsf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_req.valid),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  dnsf_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .rd_req  (rd_req),
    .rd_data (rd_data),
    .room    (room),
    .sent    (sent)
  );

endmodule

### hdl/dnsf_checker.sv
module dnsf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dnsf_pkg::BYTE_W-1:0] out_byte,
  input logic [dnsf_pkg::POS_W-1:0]  out_pos,
  input logic                        out_last
);
  import dnsf_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present straight after reset");

  a_last_newline: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_byte == CHAR_NEWLINE)
    else $error("last word is not a newline");

  a_first_dollar: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_pos == '0 |-> out_byte == CHAR_DOLLAR && !out_last)
    else $error("sentence does not open with a dollar");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_pos) && $stable(out_last))
    else $error("stalled output word changed");

endmodule

bind dollar_newline_sentence_framer_core dnsf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (sent.valid),
  .out_ready (sent.ready),
  .out_byte  (sent.sentence_byte),
  .out_pos   (sent.byte_position),
  .out_last  (sent.sentence_last)
);

### tb/dollar_newline_sentence_framer_core_tb.sv
module dollar_newline_sentence_framer_core_tb;
  import dnsf_pkg::*;

  localparam int IDLE_PCT     = 17;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_LIVE    = 165;
  localparam out_word_t NO_WORD = '0;

  typedef struct {
    logic [BYTE_W-1:0] ch;
    bit                typed;
    int                n_words;
    out_word_t         w0;
    out_word_t         w1;
  } stim_row_t;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              src_valid  = 1'b0;
  logic [BYTE_W-1:0] src_byte   = '0;
  logic              sink_ready = 1'b0;
  logic              calm       = 1'b0;
  logic              hold_go    = 1'b0;
  bit                hold_used  = 1'b0;
  int                hold_left  = 0;
  int                fault_count = 0;
  int                live_items  = 0;

  // predicted framer state
  logic [BYTE_W-1:0] frame_buf [BUFFER_DEPTH];
  int                held_len    = 0;
  bit                in_sentence = 1'b0;

  out_word_t fresh_words[$];
  out_word_t pending_words[$];
  stim_row_t dir_rows[$];

  dnsf_rx_if   rx_if ();
  dnsf_sent_if sent_if ();

  assign rx_if.valid   = src_valid;
  assign rx_if.rx_byte = src_byte;
  assign sent_if.ready = sink_ready;

  dollar_newline_sentence_framer_core u_dut (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_if),
    .sent (sent_if)
  );

  always #5 clk = ~clk;

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic out_word_t mk_word(input logic [BYTE_W-1:0] b,
                                        input logic [POS_W-1:0] p, input logic l);
    out_word_t w;
    w.sentence_byte = b;
    w.byte_position = p;
    w.sentence_last = l;
    return w;
  endfunction

  // one received character through the framer; words land in fresh_words
  task automatic frame_char(input logic [BYTE_W-1:0] c);
    int k;
    fresh_words.delete();
    if (c == CHAR_DOLLAR) begin
      frame_buf[0] = c;
      held_len     = 1;
      in_sentence  = 1'b1;
    end else if (in_sentence) begin
      if (held_len >= BUFFER_DEPTH) begin
        // store full: sentence dropped, back to hunting for '$'
        held_len    = 0;
        in_sentence = 1'b0;
      end else begin
        frame_buf[held_len] = c;
        held_len++;
        if (c == CHAR_NEWLINE) begin
          for (k = 0; k < held_len; k++)
            fresh_words.insert(fresh_words.size(),
                               mk_word(frame_buf[k], k[POS_W-1:0], k == held_len - 1));
          held_len    = 0;
          in_sentence = 1'b0;
        end
      end
    end
  endtask

  task automatic add_row(input logic [BYTE_W-1:0] ch, input bit typed, input int n,
                         input out_word_t w0, input out_word_t w1);
    stim_row_t r;
    r.ch      = ch;
    r.typed   = typed;
    r.n_words = n;
    r.w0      = w0;
    r.w1      = w1;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // valid is only dropped when a gap is taken, so back-to-back words keep it high
  task automatic send_char(input logic [BYTE_W-1:0] c, input bit keep_fresh);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      src_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    src_valid <= 1'b1;
    src_byte  <= c;
    do @(posedge clk); while (!rx_if.ready);
    if (c == CHAR_DOLLAR || in_sentence)
      live_items++;
    frame_char(c);
    if (keep_fresh)
      while (fresh_words.size() != 0)
        pending_words.insert(pending_words.size(), fresh_words.pop_front());
  endtask

  function automatic logic [BYTE_W-1:0] body_char();
    logic [BYTE_W-1:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_DOLLAR || c == CHAR_NEWLINE);
    return c;
  endfunction

  task automatic send_sentence(input int body_len, input bit closed);
    int i;
    send_char(CHAR_DOLLAR, 1'b1);
    for (i = 0; i < body_len; i++)
      send_char(body_char(), 1'b1);
    if (closed)
      send_char(CHAR_NEWLINE, 1'b1);
  endtask

  task automatic check_word();
    out_word_t want;
    if (pending_words.size() == 0) begin
      fault_count++;
      $display("%0t: unexpected word: expected none, got byte %h pos %0d last %b", $time,
               sent_if.sentence_byte, sent_if.byte_position, sent_if.sentence_last);
    end else begin
      want = pending_words.pop_front();
      if (sent_if.sentence_byte !== want.sentence_byte) begin
        fault_count++;
        $display("%0t: sentence_byte: expected %h, got %h", $time,
                 want.sentence_byte, sent_if.sentence_byte);
      end
      if (sent_if.byte_position !== want.byte_position) begin
        fault_count++;
        $display("%0t: byte_position: expected %0d, got %0d", $time,
                 want.byte_position, sent_if.byte_position);
      end
      if (sent_if.sentence_last !== want.sentence_last) begin
        fault_count++;
        $display("%0t: sentence_last: expected %b, got %b", $time,
                 want.sentence_last, sent_if.sentence_last);
      end
    end
  endtask

  // sentence side: checks each word taken, throttles ready
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      if (sent_if.valid && sent_if.ready)
        check_word();
      if (hold_go && !hold_used) begin
        hold_used  <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        sink_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    stim_row_t row;
    int        pick;
    int        n;
    int        i;

    // after reset: stray characters, then the empty sentence, then ordinary ones
    add_row(CHAR_NEWLINE, 1'b1, 0, NO_WORD, NO_WORD);
    add_row(8'hFF, 1'b1, 0, NO_WORD, NO_WORD);
    add_row(8'h00, 1'b1, 0, NO_WORD, NO_WORD);
    add_row(CHAR_DOLLAR, 1'b1, 0, NO_WORD, NO_WORD);
    add_row(CHAR_NEWLINE, 1'b1, 2, mk_word(CHAR_DOLLAR, 6'd0, 1'b0),
            mk_word(CHAR_NEWLINE, 6'd1, 1'b1));
    add_row(CHAR_DOLLAR, 1'b1, 0, NO_WORD, NO_WORD);
    add_row(8'h00, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(8'hFF, 1'b0, 0, NO_WORD, NO_WORD);
    // '$' mid-sentence restarts it
    add_row(CHAR_DOLLAR, 1'b1, 0, NO_WORD, NO_WORD);
    add_row(8'h47, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(8'h80, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(8'h7F, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(CHAR_NEWLINE, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(8'h78, 1'b1, 0, NO_WORD, NO_WORD);
    add_row(CHAR_DOLLAR, 1'b1, 0, NO_WORD, NO_WORD);
    add_row(8'h55, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(8'hAA, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(8'h01, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(8'hFE, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(CHAR_NEWLINE, 1'b0, 0, NO_WORD, NO_WORD);
    add_row(CHAR_NEWLINE, 1'b1, 0, NO_WORD, NO_WORD);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      send_char(row.ch, !row.typed);
      if (row.typed) begin
        if (row.n_words > 0) pending_words.insert(pending_words.size(), row.w0);
        if (row.n_words > 1) pending_words.insert(pending_words.size(), row.w1);
      end
    end

    // let everything drain before going random
    src_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);

    // output side stalls for a long while; the framer must back up onto rx
    live_items = 0;
    hold_go <= 1'b1;
    for (i = 0; i < 3; i++)
      send_sentence($urandom_range(2, 10), 1'b1);

    // full store, then one word too many, with no idling on either side
    calm <= 1'b1;
    send_sentence(BUFFER_DEPTH - 2, 1'b1);
    send_sentence(BUFFER_DEPTH - 1, 1'b1);
    calm <= 1'b0;

    while (live_items < RAND_LIVE) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_sentence($urandom_range(0, 12), 1'b1);
      end else if (pick < 73) begin
        send_sentence($urandom_range(BUFFER_DEPTH - 4, BUFFER_DEPTH), 1'b1);
      end else if (pick < 85) begin
        send_sentence($urandom_range(0, 8), 1'b0);
      end else begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
          send_char(8'($urandom_range(0, 255)) == CHAR_DOLLAR ? CHAR_NEWLINE :
                    8'($urandom_range(0, 255)), 1'b1);
      end
    end

    src_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
hdl/dnsf_pkg.sv
hdl/dnsf_if.sv
hdl/dnsf_ram.sv
hdl/dnsf_ctrl.sv
hdl/dnsf_outq.sv
hdl/dollar_newline_sentence_framer_core.sv
hdl/dnsf_checker.sv
tb/dollar_newline_sentence_framer_core_tb.sv
